// ===== hdl/chbp_pkg.sv =====
package chbp_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FINISH = 2'd2
  } op_e;

  // Field widths and fixed values of the stream format.
  localparam int          SYM_W      = 9;
  localparam int          LEN_W      = 5;
  localparam int          WORD_BITS  = 32;
  localparam int          CNT_W      = 6;
  localparam int          TOT_W      = 7;
  localparam int          TERMINATOR = 256;

  // Output queue sizing; one item gives at most two words.
  localparam int          OUT_DEPTH  = 8;
  localparam int          OUT_PW     = 3;
  localparam int          OUT_CW     = 4;
  localparam int          MAX_RES    = 2;

  // One result word with its end-of-stream mark.
  typedef struct packed {
    logic                 last;
    logic [WORD_BITS-1:0] word;
  } out_item_t;

  // Words produced by the packing stage in one cycle, oldest in item0.
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

endpackage

// ===== hdl/chbp_ram.sv =====
module chbp_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 257
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/chbp_out_fifo.sv =====
module chbp_out_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  chbp_pkg::push_t        push_i,
  output logic [chbp_pkg::OUT_CW-1:0] count_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [31:0]            m_axis_tdata,   // word
  output logic                   m_axis_tlast    // last
);
  import chbp_pkg::*;

  out_item_t         mem_q [OUT_DEPTH];
  logic [OUT_PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUT_PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_CW-1:0] count_q, count_d;
  logic              pop;

  // A transaction on the output side frees the head entry.
  assign pop      = (count_q != '0) && m_axis_tready;
  assign rd_ptr_d = pop ? rd_ptr_q + OUT_PW'(1) : rd_ptr_q;
  assign wr_ptr_d = wr_ptr_q + OUT_PW'(push_i.cnt);
  assign count_d  = count_q + OUT_CW'(push_i.cnt) - OUT_CW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Up to two entries are written per cycle, in order.
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.item0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + OUT_PW'(1)] <= push_i.item1;
    end
  end

  assign count_o       = count_q;
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = mem_q[rd_ptr_q].word;
  assign m_axis_tlast  = mem_q[rd_ptr_q].last;

endmodule

// ===== hdl/canonical_huffman_bit_packer.sv =====
// A result word goes through the registered table read and the packing stage
// into the output queue. Throughput: one input item per cycle; a finish item
// gives two words when the terminator code overflows the pending word, drained
// one per cycle by an eight-entry output queue that sets input tready.
// Reset clears code assignment, the bit buffer and the queue; the code table
// keeps its contents and needs no clearing pass.
module canonical_huffman_bit_packer #(
  parameter int MAX_CODE_LEN = 16,
  parameter int NUM_SYMBOLS  = 257
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // symbol [8:0], code_length [13:9], zero fill
  input  logic [1:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // word
  output logic        m_axis_tlast    // last
);
  import chbp_pkg::*;

  localparam int                AW        = $clog2(NUM_SYMBOLS);
  localparam int                EW        = MAX_CODE_LEN + LEN_W;
  localparam bit                TermOk    = NUM_SYMBOLS > TERMINATOR;
  localparam logic [31:0]       NumSymU   = 32'(NUM_SYMBOLS);
  localparam logic [LEN_W-1:0]  MaxLen    = LEN_W'(MAX_CODE_LEN);
  localparam logic [OUT_CW:0]   ReadyLim  = (OUT_CW+1)'(OUT_DEPTH - 2 * MAX_RES);

  // Input fields.
  logic             in_acc;
  logic [1:0]       in_op;
  logic [SYM_W-1:0] in_sym;
  logic [LEN_W-1:0] in_len;
  logic             sym_ok;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_op  = s_axis_tuser;
  assign in_sym = s_axis_tdata[SYM_W-1:0];
  assign in_len = s_axis_tdata[SYM_W+LEN_W-1:SYM_W];
  assign sym_ok = 32'(in_sym) < NumSymU;

  // Canonical code assignment state.
  logic [MAX_CODE_LEN:0]   next_code_q, next_code_d;
  logic [LEN_W-1:0]        cur_len_q, cur_len_d;
  logic [MAX_CODE_LEN:0]   shifted;
  logic [MAX_CODE_LEN-1:0] new_code;
  logic [MAX_CODE_LEN-1:0] rev_full;
  logic [MAX_CODE_LEN-1:0] rev_code;
  logic                    load_ok;

  // RAM ports.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  // Packing stage registers.
  logic                 s1_valid_q, s1_fin_q, s1_pack_q;
  logic                 s1_valid_d, s1_fin_d, s1_pack_d;
  logic [WORD_BITS-1:0] bit_buf_q, bit_buf_d;
  logic [CNT_W-1:0]     bit_cnt_q, bit_cnt_d;

  // A load is taken only in length order and while code space is left.
  always_comb begin
    shifted  = next_code_q << (in_len - cur_len_q);
    new_code = shifted[MAX_CODE_LEN-1:0];
    for (int i = 0; i < MAX_CODE_LEN; i++) begin
      rev_full[i] = new_code[MAX_CODE_LEN-1-i];
    end
    rev_code = rev_full >> (MaxLen - in_len);
    load_ok  = (in_len != '0) && (in_len <= MaxLen) && (in_len >= cur_len_q) && sym_ok &&
               ((next_code_q >> cur_len_q) == '0);
  end

  // Next assignment state; finish restarts the code sequence.
  always_comb begin
    next_code_d = next_code_q;
    cur_len_d   = cur_len_q;
    if (in_acc && (in_op == OP_LOAD) && load_ok) begin
      next_code_d = {1'b0, new_code} + (MAX_CODE_LEN+1)'(1);
      cur_len_d   = in_len;
    end else if (in_acc && (in_op == OP_FINISH)) begin
      next_code_d = '0;
      cur_len_d   = '0;
    end
  end

  // Table access: loads write, encode and finish read.
  always_comb begin
    ram_we    = in_acc && (in_op == OP_LOAD) && load_ok;
    ram_waddr = AW'(in_sym);
    ram_wdata = {in_len, rev_code};
    ram_re    = in_acc && ((in_op == OP_ENCODE) || (in_op == OP_FINISH));
    ram_raddr = (in_op == OP_FINISH) ? AW'(TERMINATOR) : AW'(in_sym);
  end

  chbp_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_SYMBOLS)
  ) u_code_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Stage control: what the item in the packing stage does.
  always_comb begin
    s1_valid_d = 1'b0;
    s1_fin_d   = 1'b0;
    s1_pack_d  = 1'b0;
    if (in_acc) begin
      case (op_e'(in_op))
        OP_ENCODE: begin
          s1_valid_d = 1'b1;
          s1_pack_d  = sym_ok;
        end
        OP_FINISH: begin
          s1_valid_d = 1'b1;
          s1_fin_d   = 1'b1;
          s1_pack_d  = TermOk;
        end
        default: begin
          s1_valid_d = 1'b0;
        end
      endcase
    end
  end

  // State registers of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_fin_q    <= 1'b0;
      s1_pack_q   <= 1'b0;
      next_code_q <= '0;
      cur_len_q   <= '0;
      bit_buf_q   <= '0;
      bit_cnt_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s1_fin_q    <= s1_fin_d;
      s1_pack_q   <= s1_pack_d;
      next_code_q <= next_code_d;
      cur_len_q   <= cur_len_d;
      bit_buf_q   <= bit_buf_d;
      bit_cnt_q   <= bit_cnt_d;
    end
  end

  // Packing: append the code above the pending bits, spill a full word.
  logic [LEN_W-1:0]        ent_len;
  logic [MAX_CODE_LEN-1:0] ent_code;
  logic [2*WORD_BITS-1:0]  acc;
  logic [TOT_W-1:0]        total;
  logic                    ovf;
  logic [WORD_BITS-1:0]    pk_buf;
  logic [CNT_W-1:0]        pk_cnt;
  push_t                   push;

  always_comb begin
    ent_len  = s1_pack_q ? ram_rdata[EW-1:MAX_CODE_LEN] : '0;
    ent_code = s1_pack_q ? ram_rdata[MAX_CODE_LEN-1:0] : '0;
    acc      = {{WORD_BITS{1'b0}}, bit_buf_q} | ((2*WORD_BITS)'(ent_code) << bit_cnt_q);
    total    = TOT_W'(bit_cnt_q) + TOT_W'(ent_len);
    ovf      = total > TOT_W'(WORD_BITS);
    pk_buf   = ovf ? acc[2*WORD_BITS-1:WORD_BITS] : acc[WORD_BITS-1:0];
    pk_cnt   = ovf ? CNT_W'(total - TOT_W'(WORD_BITS)) : CNT_W'(total);

    bit_buf_d = bit_buf_q;
    bit_cnt_d = bit_cnt_q;
    if (s1_valid_q) begin
      bit_buf_d = s1_fin_q ? '0 : pk_buf;
      bit_cnt_d = s1_fin_q ? '0 : pk_cnt;
    end

    // Spilled word first, then the final word of a finish.
    push.item0.last = !ovf;
    push.item0.word = ovf ? acc[WORD_BITS-1:0] : pk_buf;
    push.item1.last = 1'b1;
    push.item1.word = pk_buf;
    push.cnt        = s1_valid_q ? 2'(ovf) + 2'(s1_fin_q) : 2'd0;
  end

  // Output queue; input is taken only while room is left for two items.
  logic [OUT_CW-1:0] q_count;
  logic [OUT_CW:0]   q_need;

  chbp_out_fifo u_out_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .count_o      (q_count),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  assign q_need        = {1'b0, q_count} + (s1_valid_q ? (OUT_CW+1)'(MAX_RES) : '0);
  assign s_axis_tready = q_need <= ReadyLim;

endmodule
